### hdl/assert_macros.svh
// assertion helpers for the checkers of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GYI_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the following cycle
`define GYI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// delayed consequent
`define GYI_ASSERT_DELAY2(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### hdl/gyi_pkg.sv
package gyi_pkg;

    localparam int CMD_W     = 3;
    localparam int RAW_W     = 16;
    localparam int TICK_W    = 32;
    localparam int YAW_W     = 48;
    localparam int BIAS_W    = 24;
    localparam int CNT_OUT_W = 9;
    localparam int STATUS_W  = 2;
    localparam int Q8_SH     = 8;

    localparam int MAX_CAL_SAMPLES_DEF = 256;

    // 256 / 131000 reduces to 32 / 16375
    localparam int SCALE_SH = 5;
    localparam int K_W      = 14;
    localparam logic [K_W-1:0] K_DIV = 14'd16375;

    // rate magnitude in q8 counts, product with the tick delta
    localparam int MAG_W  = BIAS_W + 1;
    localparam int PROD_W = MAG_W + TICK_W;

    // divider dividend window (even), bits above it preload the remainder
    localparam int DVD_W  = 50;
    localparam int PRE_W  = PROD_W + SCALE_SH - DVD_W;
    localparam int STEP_W = $clog2(DVD_W / 2 + 1);

    localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CAL_BEGIN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CAL_SAMPLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CAL_FINISH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET_YAW  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INIT       = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SKIP       = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SAMPLES = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_APPLY
    } t_state;

endpackage

### hdl/gyi_mul.sv
module gyi_mul
    import gyi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_a,
    input  logic [TICK_W-1:0] i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    localparam int STEPS = TICK_W / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [MAG_W-1:0]  r_a;
    logic [MAG_W+1:0]  r_a3;
    logic [MAG_W-1:0]  r_acc;
    logic [TICK_W-1:0] r_lo;
    logic [TICK_W-1:0] r_b;

    logic [MAG_W+1:0]  addend;
    logic [MAG_W+1:0]  sum;

    // radix-4 shift-add, two product bits retire per cycle
    always_comb begin
        case (r_b[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = (MAG_W+2)'(r_a);
            2'd2:    addend = (MAG_W+2)'({r_a, 1'b0});
            default: addend = r_a3;
        endcase
        sum = (MAG_W+2)'(r_acc) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_a3  <= (MAG_W+2)'(i_a) + (MAG_W+2)'({i_a, 1'b0});
            r_acc <= '0;
            r_lo  <= '0;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= sum[MAG_W+1:2];
            r_lo  <= {sum[1:0], r_lo[TICK_W-1:2]};
            r_b   <= {2'b00, r_b[TICK_W-1:2]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_acc, r_lo};

endmodule

### hdl/gyi_div.sv
module gyi_div
    import gyi_pkg::*;
#(
    parameter int DIVR_W = K_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dvd,
    input  logic [DIVR_W-1:0] i_rem,
    input  logic [DIVR_W-1:0] i_dvs,
    input  logic [STEP_W-1:0] i_steps,
    output logic              o_done,
    output logic [DVD_W-1:0]  o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVR_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVD_W-1:0]  r_quo;
    logic [DIVR_W+1:0] r_d1;
    logic [DIVR_W+1:0] r_d2;
    logic [DIVR_W+1:0] r_d3;

    logic [DIVR_W+1:0] trial;
    logic [DIVR_W+1:0] rem_full;
    logic [1:0]        digit;

    // radix-4 restoring step, remainder stays below the divisor
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1 -: 2]};
        if (trial >= r_d3) begin
            digit    = 2'd3;
            rem_full = trial - r_d3;
        end else if (trial >= r_d2) begin
            digit    = 2'd2;
            rem_full = trial - r_d2;
        end else if (trial >= r_d1) begin
            digit    = 2'd1;
            rem_full = trial - r_d1;
        end else begin
            digit    = 2'd0;
            rem_full = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_dvd <= i_dvd;
            r_quo <= '0;
            r_d1  <= (DIVR_W+2)'(i_dvs);
            r_d2  <= (DIVR_W+2)'({i_dvs, 1'b0});
            r_d3  <= (DIVR_W+2)'(i_dvs) + (DIVR_W+2)'({i_dvs, 1'b0});
        end else if (r_busy) begin
            r_rem <= rem_full[DIVR_W-1:0];
            r_dvd <= {r_dvd[DVD_W-3:0], 2'b00};
            r_quo <= {r_quo[DVD_W-3:0], digit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hdl/gyro_yaw_integrator.sv
// update with a good sample: multiply, then divide, then apply (16 multiply steps
// on the radix-4 shift-add unit, 25 steps of the radix-4 divider by 16375, control)
// calibration finish with samples: the divider alone, over the scaled sum
// others: apply only; one item in flight, the next is taken once the result is out
// synchronous active-low reset clears yaw, bias, last tick and the calibration gatherer
module gyro_yaw_integrator
    import gyi_pkg::*;
#(
    parameter int MAX_CAL_SAMPLES = MAX_CAL_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [RAW_W-1:0]    i_gyro_raw,
    input  logic                       i_read_ok,
    input  logic [TICK_W-1:0]          i_tick_ms,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [YAW_W-1:0]    o_yaw_q16,
    output logic signed [BIAS_W-1:0]   o_bias_q8,
    output logic [CNT_OUT_W-1:0]       o_cal_count,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int SUM_W  = RAW_W + 1 + $clog2(MAX_CAL_SAMPLES);
    localparam int DIVR_W = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int FIN_W  = ((SUM_W + Q8_SH + 1) / 2) * 2;
    localparam logic [STEP_W-1:0] UPD_STEPS = STEP_W'(DVD_W / 2);
    localparam logic [STEP_W-1:0] FIN_STEPS = STEP_W'(FIN_W / 2);
    localparam logic [YAW_W-1:0]  YAW_MAX   = {1'b0, {(YAW_W-1){1'b1}}};
    localparam logic [YAW_W-1:0]  YAW_MIN   = {1'b1, {(YAW_W-1){1'b0}}};

    t_state                    r_state;
    t_state                    n_state;

    logic [CMD_W-1:0]          r_cmd;
    logic signed [RAW_W-1:0]   r_raw;
    logic                      r_ok;
    logic [TICK_W-1:0]         r_tick;
    logic                      r_neg;

    logic signed [YAW_W-1:0]   r_yaw;
    logic signed [BIAS_W-1:0]  r_bias;
    logic [TICK_W-1:0]         r_last;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic [STATUS_W-1:0]       r_status;
    logic                      r_out_valid;

    logic signed [YAW_W-1:0]   n_yaw;
    logic signed [BIAS_W-1:0]  n_bias;
    logic [TICK_W-1:0]         n_last;
    logic signed [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]          n_cnt;
    logic [STATUS_W-1:0]       n_status;

    logic                      in_accept;
    logic                      out_free;
    logic                      mul_start;
    logic                      div_start;
    logic                      apply_en;

    logic signed [BIAS_W-1:0]  raw_q8;
    logic signed [MAG_W:0]     upd_diff;
    logic                      upd_neg;
    logic [MAG_W-1:0]          upd_mag;
    logic [TICK_W-1:0]         upd_dt;

    logic                      fin_neg;
    logic [SUM_W-1:0]          fin_mag;
    logic [DVD_W-1:0]          fin_dvd;

    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic [PROD_W+SCALE_SH-1:0] p32;

    logic [DVD_W-1:0]          div_dvd;
    logic [DIVR_W-1:0]         div_rem;
    logic [DIVR_W-1:0]         div_dvs;
    logic [STEP_W-1:0]         div_steps;
    logic                      div_done;
    logic [DVD_W-1:0]          div_quo;

    logic [YAW_W+1:0]          inc_u;
    logic signed [YAW_W+1:0]   upd_inc;
    logic signed [YAW_W+1:0]   yaw_sum;
    logic signed [YAW_W-1:0]   yaw_sat;
    logic [BIAS_W-1:0]         q_bias;
    logic signed [BIAS_W-1:0]  fin_bias;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // operands for an update, from the item on the ports
    assign raw_q8   = {i_gyro_raw, {Q8_SH{1'b0}}};
    assign upd_diff = (MAG_W+1)'(raw_q8) - (MAG_W+1)'(r_bias);
    assign upd_neg  = upd_diff[MAG_W];
    assign upd_mag  = upd_neg ? MAG_W'(-upd_diff) : MAG_W'(upd_diff);
    assign upd_dt   = i_tick_ms - r_last;

    // operands for a calibration finish: |sum| * 256 left-aligned in the dividend
    assign fin_neg = r_sum[SUM_W-1];
    assign fin_mag = fin_neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign fin_dvd = DVD_W'(fin_mag) << (DVD_W - FIN_W + Q8_SH);

    assign p32 = {mul_prod, {SCALE_SH{1'b0}}};

    always_comb begin
        if (r_state == S_IDLE) begin
            div_dvd   = fin_dvd;
            div_rem   = '0;
            div_dvs   = DIVR_W'(r_cnt);
            div_steps = FIN_STEPS;
        end else begin
            // top bits of the scaled product are below 16375, so they seed the remainder
            div_dvd   = p32[DVD_W-1:0];
            div_rem   = DIVR_W'(p32[PROD_W+SCALE_SH-1 -: PRE_W]);
            div_dvs   = DIVR_W'(K_DIV);
            div_steps = UPD_STEPS;
        end
    end

    gyi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (upd_mag),
        .i_b     (upd_dt),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    gyi_div #(
        .DIVR_W (DIVR_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_rem   (div_rem),
        .i_dvs   (div_dvs),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        div_start = 1'b0;
        apply_en  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_command == CMD_UPDATE && i_read_ok) begin
                        mul_start = 1'b1;
                        n_state   = S_MUL;
                    end else if (i_command == CMD_CAL_FINISH && r_cnt != '0) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    apply_en = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // yaw step with saturation to the 48-bit range
    assign inc_u   = (YAW_W+2)'(div_quo[YAW_W-1:0]);
    assign upd_inc = r_neg ? -inc_u : inc_u;
    assign yaw_sum = (YAW_W+2)'(r_yaw) + upd_inc;

    always_comb begin
        if (yaw_sum[YAW_W+1:YAW_W-1] == 3'b000 || yaw_sum[YAW_W+1:YAW_W-1] == 3'b111) begin
            yaw_sat = yaw_sum[YAW_W-1:0];
        end else if (yaw_sum[YAW_W+1]) begin
            yaw_sat = YAW_MIN;
        end else begin
            yaw_sat = YAW_MAX;
        end
    end

    assign q_bias   = div_quo[BIAS_W-1:0];
    assign fin_bias = r_neg ? -q_bias : q_bias;

    always_comb begin
        n_yaw    = r_yaw;
        n_bias   = r_bias;
        n_last   = r_last;
        n_sum    = r_sum;
        n_cnt    = r_cnt;
        n_status = STAT_OK;
        unique case (r_cmd)
            CMD_UPDATE: begin
                if (!r_ok) begin
                    n_status = STAT_SKIP;
                end else begin
                    n_yaw  = yaw_sat;
                    n_last = r_tick;
                end
            end
            CMD_CAL_BEGIN: begin
                n_sum = '0;
                n_cnt = '0;
            end
            CMD_CAL_SAMPLE: begin
                if (!r_ok) begin
                    n_status = STAT_SKIP;
                end else if (r_cnt >= CNT_W'(MAX_CAL_SAMPLES)) begin
                    n_status = STAT_FULL;
                end else begin
                    n_sum = r_sum + SUM_W'(r_raw);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            CMD_CAL_FINISH: begin
                if (r_cnt == '0) begin
                    n_status = STAT_NO_SAMPLES;
                end else begin
                    n_bias = fin_bias;
                    n_yaw  = '0;
                    n_last = r_tick;
                end
            end
            CMD_RESET_YAW: begin
                n_yaw  = '0;
                n_last = r_tick;
            end
            CMD_INIT: begin
                n_yaw  = '0;
                n_bias = '0;
                n_last = r_tick;
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    // item fields held while it is worked on
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= i_command;
            r_raw  <= i_gyro_raw;
            r_ok   <= i_read_ok;
            r_tick <= i_tick_ms;
            r_neg  <= (i_command == CMD_UPDATE) ? upd_neg : fin_neg;
        end
    end

    // state changes only when the result register is free, so it doubles as output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw       <= '0;
            r_bias      <= '0;
            r_last      <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (apply_en) begin
            r_yaw       <= n_yaw;
            r_bias      <= n_bias;
            r_last      <= n_last;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_en) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_yaw_q16   = r_yaw;
    assign o_bias_q8   = r_bias;
    assign o_cal_count = CNT_OUT_W'(r_cnt);
    assign o_status    = r_status;

endmodule

### hdl/gyi_chk.sv
`include "assert_macros.svh"

module gyi_chk
    import gyi_pkg::*;
#(
    parameter int MAX_CAL_SAMPLES = MAX_CAL_SAMPLES_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic [CMD_W-1:0]         i_command,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [YAW_W-1:0]  o_yaw_q16,
    input logic signed [BIAS_W-1:0] o_bias_q8,
    input logic [CNT_OUT_W-1:0]     o_cal_count,
    input logic [STATUS_W-1:0]      o_status
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    // one item at a time
    `GYI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready, "ready after accept")

    `GYI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_yaw_q16) && $stable(o_bias_q8) && $stable(o_cal_count) && $stable(o_status), "stalled result changed")

    // reset yaw and init, accepted with no result pending, show a cleared yaw once the apply state has registered it
    `GYI_ASSERT_DELAY2(a_yaw_cleared, i_clk, i_rst_n, in_acc && !o_out_valid && (i_command == CMD_RESET_YAW || i_command == CMD_INIT), o_out_valid && o_yaw_q16 == '0 && o_status == STAT_OK, "yaw not cleared")

    `GYI_ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, o_out_valid && o_status == STAT_FULL, o_cal_count == CNT_OUT_W'(MAX_CAL_SAMPLES), "store full with wrong count")

    `GYI_ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n, o_out_valid && o_status == STAT_NO_SAMPLES, o_cal_count == '0, "no samples with nonzero count")

endmodule

bind gyro_yaw_integrator gyi_chk #(
    .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES)
) u_chk (.*);

### tb/gyro_yaw_integrator_checker.sv
module gyro_yaw_integrator_checker
    import gyi_pkg::*;
#(
    parameter int MAX_CAL_SAMPLES = MAX_CAL_SAMPLES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [RAW_W-1:0]  i_gyro_raw,
    input  logic                     i_read_ok,
    input  logic [TICK_W-1:0]        i_tick_ms,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [YAW_W-1:0]  i_yaw_q16,
    input  logic signed [BIAS_W-1:0] i_bias_q8,
    input  logic [CNT_OUT_W-1:0]     i_cal_count,
    input  logic [STATUS_W-1:0]      i_status,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint YAW_HI = (64'sd1 <<< (YAW_W - 1)) - 64'sd1;
    localparam longint YAW_LO = -(64'sd1 <<< (YAW_W - 1));

    typedef struct packed {
        logic signed [YAW_W-1:0]  yaw;
        logic signed [BIAS_W-1:0] bias;
        logic [CNT_OUT_W-1:0]     count;
        logic [STATUS_W-1:0]      status;
    } t_yaw_result;

    // own copy of the integrator state
    longint            yaw_acc;
    int                bias_acc;
    logic [TICK_W-1:0] last_tick;
    int                cal_sum;
    int                cal_samples;

    t_yaw_result yaw_results_q[$];
    int          mismatches = 0;
    int          waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic t_yaw_result predict_yaw_step(
        input logic [CMD_W-1:0]        cmd,
        input logic signed [RAW_W-1:0] raw,
        input logic                    ok,
        input logic [TICK_W-1:0]       tick
    );
        t_yaw_result         r;
        logic [STATUS_W-1:0] st;
        logic [TICK_W-1:0]   dt;
        longint              rate;
        longint              sum_q8;
        longint              next_yaw;
        logic [63:0]         mag;
        logic [63:0]         quo;
        st = STAT_OK;
        case (cmd)
            CMD_UPDATE: begin
                if (!ok) begin
                    st = STAT_SKIP;
                end else begin
                    dt   = tick - last_tick;
                    rate = longint'(raw) * 256 - longint'(bias_acc);
                    mag  = (rate < 0) ? -rate : rate;
                    quo  = ((mag * {32'd0, dt}) << SCALE_SH) / {50'd0, K_DIV};
                    next_yaw = (rate < 0) ? yaw_acc - longint'(quo) : yaw_acc + longint'(quo);
                    if (next_yaw > YAW_HI) next_yaw = YAW_HI;
                    if (next_yaw < YAW_LO) next_yaw = YAW_LO;
                    yaw_acc   = next_yaw;
                    last_tick = tick;
                end
            end
            CMD_CAL_BEGIN: begin
                cal_sum     = 0;
                cal_samples = 0;
            end
            CMD_CAL_SAMPLE: begin
                if (!ok) begin
                    st = STAT_SKIP;
                end else if (cal_samples >= MAX_CAL_SAMPLES) begin
                    st = STAT_FULL;
                end else begin
                    cal_sum     = cal_sum + raw;
                    cal_samples = cal_samples + 1;
                end
            end
            CMD_CAL_FINISH: begin
                if (cal_samples == 0) begin
                    st = STAT_NO_SAMPLES;
                end else begin
                    sum_q8   = longint'(cal_sum) * 256;
                    mag      = (sum_q8 < 0) ? -sum_q8 : sum_q8;
                    quo      = mag / cal_samples;
                    bias_acc = (sum_q8 < 0) ? -int'(quo) : int'(quo);
                    yaw_acc   = 0;
                    last_tick = tick;
                end
            end
            CMD_RESET_YAW: begin
                yaw_acc   = 0;
                last_tick = tick;
            end
            CMD_INIT: begin
                yaw_acc   = 0;
                bias_acc  = 0;
                last_tick = tick;
            end
            default: ;
        endcase
        r.yaw    = yaw_acc[YAW_W-1:0];
        r.bias   = bias_acc[BIAS_W-1:0];
        r.count  = cal_samples[CNT_OUT_W-1:0];
        r.status = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_yaw_result got;
        t_yaw_result want;
        if (!i_rst_n) begin
            yaw_acc     = 0;
            bias_acc    = 0;
            last_tick   = '0;
            cal_sum     = 0;
            cal_samples = 0;
            yaw_results_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                yaw_results_q.push_back(
                    predict_yaw_step(i_command, i_gyro_raw, i_read_ok, i_tick_ms));
            if (i_out_valid && i_out_ready) begin
                got = {i_yaw_q16, i_bias_q8, i_cal_count, i_status};
                if (yaw_results_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%t: result with nothing expected: yaw %0d bias %0d cnt %0d st %0d",
                                 $realtime, got.yaw, got.bias, got.count, got.status);
                    mismatches++;
                end else begin
                    want = yaw_results_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("%t: mismatch, expected yaw %0d bias %0d cnt %0d st %0d",
                                     $realtime, want.yaw, want.bias, want.count, want.status);
                            $display("%t:           actual yaw %0d bias %0d cnt %0d st %0d",
                                     $realtime, got.yaw, got.bias, got.count, got.status);
                        end
                        mismatches++;
                    end
                end
            end
        end
        waiting = yaw_results_q.size();
    end

endmodule

### tb/gyro_yaw_integrator_tb.sv
module gyro_yaw_integrator_tb;
    import gyi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam int ITEM_TARGET    = 2000;

    // codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_command = '0;
    logic signed [RAW_W-1:0]  i_gyro_raw = '0;
    logic                     i_read_ok = 1'b0;
    logic [TICK_W-1:0]        i_tick_ms = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [YAW_W-1:0]  o_yaw_q16;
    logic signed [BIAS_W-1:0] o_bias_q8;
    logic [CNT_OUT_W-1:0]     o_cal_count;
    logic [STATUS_W-1:0]      o_status;

    int                fail_count;
    int                results_waiting;
    int                items_sent = 0;
    int                quiet_cycles = 0;
    int                sink_hold = 0;
    bit                sink_burst = 1'b0;
    bit                send_burst = 1'b0;
    logic [TICK_W-1:0] tick_now = '0;

    gyro_yaw_integrator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_gyro_raw  (i_gyro_raw),
        .i_read_ok   (i_read_ok),
        .i_tick_ms   (i_tick_ms),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_yaw_q16   (o_yaw_q16),
        .o_bias_q8   (o_bias_q8),
        .o_cal_count (o_cal_count),
        .o_status    (o_status)
    );

    gyro_yaw_integrator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_gyro_raw   (i_gyro_raw),
        .i_read_ok    (i_read_ok),
        .i_tick_ms    (i_tick_ms),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_yaw_q16    (o_yaw_q16),
        .i_bias_q8    (o_bias_q8),
        .i_cal_count  (o_cal_count),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (results_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [RAW_W-1:0] rand_rate();
        logic signed [RAW_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2, 3, 4: v = RAW_W'($urandom());
            default: v = RAW_W'($urandom_range(0, 800) - 400);
        endcase
        return v;
    endfunction

    function automatic logic [TICK_W-1:0] rand_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 20);
        if (r < 92) return $urandom_range(21, 3000);
        return $urandom();
    endfunction

    task automatic send_item(
        input logic [CMD_W-1:0]        cmd,
        input logic signed [RAW_W-1:0] raw,
        input logic                    ok,
        input logic [TICK_W-1:0]       tick
    );
        int gap;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_gyro_raw <= raw;
        i_read_ok  <= ok;
        i_tick_ms  <= tick;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        gap = send_burst ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_update(
        input logic signed [RAW_W-1:0] raw,
        input logic                    ok,
        input logic [TICK_W-1:0]       dt
    );
        tick_now = tick_now + dt;
        send_item(CMD_UPDATE, raw, ok, tick_now);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_waiting != 0) @(negedge i_clk);
    endtask

    // sink: random stalls with calm stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            i_out_ready <= 1'b0;
            sink_hold   <= sink_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!sink_burst) sink_hold <= idle_len();
        end
        if ($urandom_range(0, 199) == 0) sink_burst <= ~sink_burst;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                      n;
        logic signed [RAW_W-1:0] center;
        logic signed [RAW_W-1:0] jitter;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        tick_now = 32'h10;
        send_item(CMD_INIT, 16'sh0, 1'b1, tick_now);
        send_item(CMD_CAL_FINISH, 16'sh7FFF, 1'b0, tick_now);   // no samples yet
        send_item(CMD_CAL_BEGIN, 16'sh0, 1'b0, tick_now);
        send_item(CMD_CAL_SAMPLE, 16'sh7FFF, 1'b0, tick_now);   // failed read
        send_item(CMD_CAL_SAMPLE, 16'sh7FFF, 1'b1, tick_now);
        send_item(CMD_CAL_SAMPLE, 16'sh8000, 1'b1, tick_now);
        send_item(CMD_CAL_SAMPLE, 16'sd100, 1'b1, tick_now);
        send_item(CMD_CAL_FINISH, 16'sh0, 1'b0, tick_now);
        send_item(CMD_CAL_FINISH, 16'sh0, 1'b1, tick_now);      // same bias again
        send_update(16'sh7FFF, 1'b0, 32'd1000);
        send_update(16'sh0, 1'b1, 32'd0);
        repeat (3) send_update(16'sh7FFF, 1'b1, 32'hFFFF_FFFF);  // drives to positive limit
        send_item(CMD_INIT, 16'sh0, 1'b1, tick_now);
        repeat (3) send_update(16'sh8000, 1'b1, 32'hFFFF_FFFF);  // negative limit
        tick_now = 32'hFFFF_FFF0;
        send_item(CMD_RESET_YAW, 16'sh0, 1'b0, tick_now);
        send_update(16'sd1000, 1'b1, 32'd40);                    // tick wraps past zero
        send_item(CMD_SPARE_6, 16'sh5A5A, 1'b1, 32'hA5A5_A5A5);
        send_item(CMD_SPARE_7, 16'shA5A5, 1'b0, 32'h5A5A_5A5A);
        // most negative bias, then most positive
        send_item(CMD_CAL_BEGIN, 16'sh0, 1'b1, tick_now);
        send_item(CMD_CAL_SAMPLE, 16'sh8000, 1'b1, tick_now);
        send_item(CMD_CAL_FINISH, 16'sh0, 1'b1, tick_now);
        send_update(16'sh7FFF, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_CAL_BEGIN, 16'sh0, 1'b1, tick_now);
        send_item(CMD_CAL_SAMPLE, 16'sh7FFF, 1'b1, tick_now);
        send_item(CMD_CAL_FINISH, 16'sh0, 1'b1, tick_now);
        send_update(16'sh8000, 1'b1, 32'hFFFF_FFFF);
        drain_results();

        // fill the calibration store past its limit
        send_item(CMD_CAL_BEGIN, 16'sh0, 1'b1, tick_now);
        center = rand_rate();
        repeat (MAX_CAL_SAMPLES_DEF + 1) begin
            jitter = RAW_W'($urandom_range(0, 63) - 32);
            send_item(CMD_CAL_SAMPLE, center + jitter, 1'b1, $urandom());
        end
        repeat (3) send_item(CMD_CAL_SAMPLE, rand_rate(), 1'($urandom_range(0, 1)), $urandom());
        send_item(CMD_CAL_FINISH, 16'sh0, 1'($urandom_range(0, 1)), tick_now);

        // random part
        while (items_sent < ITEM_TARGET) begin
            send_burst = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 19))
                9, 10, 11, 12: begin
                    if ($urandom_range(0, 4) != 0)
                        send_item(CMD_CAL_BEGIN, rand_rate(), 1'($urandom_range(0, 1)),
                                  $urandom());
                    n = $urandom_range(0, 16);
                    center = rand_rate();
                    repeat (n) begin
                        jitter = ($urandom_range(0, 3) == 0) ? rand_rate()
                                 : RAW_W'($urandom_range(0, 63) - 32);
                        send_item(CMD_CAL_SAMPLE, center + jitter,
                                  ($urandom_range(0, 9) != 0), $urandom());
                    end
                    tick_now = tick_now + rand_dt();
                    send_item(CMD_CAL_FINISH, rand_rate(), 1'($urandom_range(0, 1)), tick_now);
                    if ($urandom_range(0, 2) == 0)
                        send_item(CMD_CAL_FINISH, rand_rate(), 1'($urandom_range(0, 1)),
                                  tick_now);
                end
                13, 14: begin
                    tick_now = tick_now + rand_dt();
                    send_item(($urandom_range(0, 1) == 0) ? CMD_RESET_YAW : CMD_INIT,
                              rand_rate(), 1'($urandom_range(0, 1)), tick_now);
                end
                15, 16: begin
                    repeat ($urandom_range(1, 4))
                        send_item(CMD_W'($urandom_range(0, 7)), RAW_W'($urandom()),
                                  1'($urandom_range(0, 1)), $urandom());
                end
                17: drain_results();
                18: begin
                    // rare long gather that overruns the store
                    if ($urandom_range(0, 5) == 0) begin
                        send_item(CMD_CAL_BEGIN, 16'sh0, 1'b1, tick_now);
                        center = rand_rate();
                        repeat (MAX_CAL_SAMPLES_DEF + $urandom_range(1, 4))
                            send_item(CMD_CAL_SAMPLE, center, ($urandom_range(0, 19) != 0),
                                      $urandom());
                        send_item(CMD_CAL_FINISH, 16'sh0, 1'b1, tick_now);
                    end
                end
                19: begin
                    tick_now = $urandom();
                    send_item(CMD_RESET_YAW, rand_rate(), 1'($urandom_range(0, 1)), tick_now);
                end
                default: begin
                    repeat ($urandom_range(1, 24))
                        send_update(rand_rate(), ($urandom_range(0, 9) != 0), rand_dt());
                end
            endcase
        end

        i_in_valid <= 1'b0;
        while (results_waiting != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && results_waiting == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
